[rtl/lzwsd_pkg.sv]
`default_nettype none
package lzwsd_pkg;
   localparam int MAX_CODE_BITS = 12;
   localparam int TABLE_DEPTH   = 4096;
   localparam int TBL_AW        = $clog2(TABLE_DEPTH);
   localparam int NF_W          = TBL_AW + 1;
   localparam int WID_W         = $clog2(MAX_CODE_BITS + 1);
   localparam int CLEAR_CODE    = 256;
   localparam int FIRST_FREE    = 257;
   localparam int START_BITS    = 9;
   localparam int STACK_DEPTH   = ((TABLE_DEPTH - 256 + 63) / 64 + 1) * 64;
   localparam int STACK_AW      = $clog2(STACK_DEPTH);
   localparam int LEN_W         = $clog2(STACK_DEPTH + 1);
   localparam int CHUNK_BYTES   = 64;
   localparam int CNT_W         = 7;

   // one completed code handed from the front end to the expander
   typedef struct packed {
      logic                     valid;
      logic                     first;
      logic                     kwkwk;
      logic                     wr_en;
      logic [MAX_CODE_BITS-1:0] code;
      logic [MAX_CODE_BITS-1:0] prev;
      logic [TBL_AW-1:0]        wr_addr;
   } cmd_type;

   // one finished chunk from the expander
   typedef struct packed {
      logic                       valid;
      logic [CHUNK_BYTES*8-1:0]   bytes;
      logic [CNT_W-1:0]           count;
      logic                       last;
   } chunk_type;
endpackage
`default_nettype wire

[rtl/lzwsd_ram.sv]
`default_nettype none
module lzwsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/lzwsd_unpack.sv]
`default_nettype none
module lzwsd_unpack (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 accept,
   input  wire [7:0]           in_byte,
   input  wire                 restart,
   output lzwsd_pkg::cmd_type  cmd
);
   import lzwsd_pkg::*;

   typedef enum logic [1:0] {PH_RUN, PH_DROP_ONE, PH_KEEP_ONE, PH_DISCARD} phase_type;

   localparam int EXT_W = MAX_CODE_BITS + 8;

   phase_type               phase_ff, phase_in;
   logic [MAX_CODE_BITS-1:0] accum_ff, accum_in;
   logic [WID_W-1:0]         abits_ff, abits_in;
   logic [WID_W-1:0]         width_ff, width_in;
   logic [NF_W-1:0]          free_ff, free_in;
   logic [MAX_CODE_BITS-1:0] prev_ff, prev_in;
   logic [6:0]               bsc_ff, bsc_in;
   logic [4:0]               disc_ff, disc_in;
   logic                     first_ff, first_in;

   logic [EXT_W-1:0]         ext, mask;
   logic [WID_W:0]           bit_sum;
   logic [MAX_CODE_BITS-1:0] code;
   logic [6:0]               nb8, bsc_t, a;
   logic [NF_W-1:0]          free_t;
   logic                     was_keep, cleared;

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      abits_in = abits_ff;
      width_in = width_ff;
      free_in  = free_ff;
      prev_in  = prev_ff;
      bsc_in   = bsc_ff;
      disc_in  = disc_ff;
      first_in = first_ff;
      cmd      = '0;
      cleared  = 1'b0;
      ext      = '0;
      mask     = '0;
      bit_sum  = '0;
      code     = '0;
      nb8      = '0;
      bsc_t    = '0;
      a        = '0;
      free_t   = '0;
      was_keep = 1'b0;
      if (accept) begin
         // start of stream restores the scalar state first
         if (restart) begin
            phase_in = PH_RUN;
            accum_in = '0;
            abits_in = '0;
            width_in = WID_W'(START_BITS);
            free_in  = NF_W'(FIRST_FREE);
            prev_in  = '0;
            bsc_in   = '0;
            disc_in  = '0;
            first_in = 1'b1;
         end
         case (phase_in)
            PH_DROP_ONE: phase_in = PH_KEEP_ONE;
            PH_DISCARD: begin
               if (disc_in != '0) disc_in = disc_in - 5'd1;
               if (disc_in == '0) phase_in = PH_RUN;
            end
            default: begin
               was_keep = (phase_in == PH_KEEP_ONE);
               ext  = EXT_W'(accum_in) | (EXT_W'(in_byte) << abits_in);
               bit_sum = {1'b0, abits_in} + (WID_W+1)'(8);
               if (bit_sum < {1'b0, width_in}) begin
                  accum_in = MAX_CODE_BITS'(ext);
                  abits_in = WID_W'(bit_sum);
               end else begin
                  mask = (EXT_W'(1) << width_in) - EXT_W'(1);
                  code = MAX_CODE_BITS'(ext & mask);
                  accum_in = MAX_CODE_BITS'(ext >> width_in);
                  abits_in = WID_W'(bit_sum - {1'b0, width_in});
                  if (first_in) begin
                     // first code goes out as its low byte
                     first_in    = 1'b0;
                     prev_in     = code;
                     cmd.valid   = 1'b1;
                     cmd.first   = 1'b1;
                     cmd.code    = code;
                  end else begin
                     nb8   = {width_in, 3'b000};
                     bsc_t = bsc_in + 7'(width_in);
                     if (bsc_t >= nb8) bsc_t = bsc_t - nb8;
                     bsc_in = bsc_t;
                     if (code == MAX_CODE_BITS'(CLEAR_CODE)) begin
                        // clear: drop alignment padding after the code
                        a = (bsc_t == '0) ? nb8 - 7'd1 : bsc_t - 7'd1;
                        disc_in  = 5'((nb8 - 7'd1 - a) >> 3);
                        width_in = WID_W'(START_BITS);
                        free_in  = NF_W'(CLEAR_CODE);
                        bsc_in   = '0;
                        phase_in = (abits_in != '0) ? PH_DROP_ONE : PH_KEEP_ONE;
                        accum_in = '0;
                        abits_in = '0;
                        cleared  = 1'b1;
                     end else begin
                        cmd.valid   = 1'b1;
                        cmd.code    = code;
                        cmd.prev    = prev_in;
                        cmd.kwkwk   = (NF_W'(code) >= free_in);
                        cmd.wr_en   = (free_in < NF_W'(TABLE_DEPTH));
                        cmd.wr_addr = TBL_AW'(free_in);
                        if (cmd.wr_en) begin
                           free_t  = free_in + NF_W'(1);
                           free_in = free_t;
                           if (free_t >= (NF_W'(1) << width_in) &&
                               width_in < WID_W'(MAX_CODE_BITS)) begin
                              width_in = width_in + WID_W'(1);
                              bsc_in   = '0;
                           end
                        end
                        prev_in = code;
                     end
                  end
               end
               if (was_keep && !cleared)
                  phase_in = (disc_in != '0) ? PH_DISCARD : PH_RUN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RUN;
         accum_ff <= '0;
         abits_ff <= '0;
         width_ff <= WID_W'(START_BITS);
         free_ff  <= NF_W'(FIRST_FREE);
         prev_ff  <= '0;
         bsc_ff   <= '0;
         disc_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         abits_ff <= abits_in;
         width_ff <= width_in;
         free_ff  <= free_in;
         prev_ff  <= prev_in;
         bsc_ff   <= bsc_in;
         disc_ff  <= disc_in;
         first_ff <= first_in;
      end
   end
endmodule
`default_nettype wire

[rtl/lzwsd_expand.sv]
`default_nettype none
module lzwsd_expand (
   input  wire                   clock,
   input  wire                   reset,
   input  lzwsd_pkg::cmd_type    cmd,
   input  wire                   out_free,
   output logic                  busy,
   output lzwsd_pkg::chunk_type  chunk
);
   import lzwsd_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_WALK, S_WAIT, S_EMIT, S_PUSH} state_type;

   localparam int TW = MAX_CODE_BITS + 8;

   state_type                state_ff, state_in;
   logic [MAX_CODE_BITS-1:0] cur_ff, cur_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         pos_ff, pos_in;
   logic [7:0]               sym_ff, sym_in;
   logic [MAX_CODE_BITS-1:0] prev_ff, prev_in;
   logic                     wen_ff, wen_in;
   logic [TBL_AW-1:0]        waddr_ff, waddr_in;
   logic [CNT_W-1:0]         take_ff, take_in;
   logic [CNT_W-1:0]         issue_ff, issue_in;
   logic [CNT_W-1:0]         cap_ff, cap_in;
   logic                     pend_ff, pend_in;
   logic [CHUNK_BYTES*8-1:0] build_ff, build_in;

   logic                     st_we, tb_we;
   logic [STACK_AW-1:0]      st_waddr, st_raddr;
   logic [7:0]               st_wdata, st_rdata;
   logic [TBL_AW-1:0]        tb_raddr;
   logic [TW-1:0]            tb_wdata, tb_rdata;
   logic [LEN_W-1:0]         pos_t;

   lzwsd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   // prefix in the high bits, append byte in the low bits
   lzwsd_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock(clock), .wr_en(tb_we), .wr_addr(waddr_ff), .wr_data(tb_wdata),
      .rd_addr(tb_raddr), .rd_data(tb_rdata)
   );

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      sym_in   = sym_ff;
      prev_in  = prev_ff;
      wen_in   = wen_ff;
      waddr_in = waddr_ff;
      take_in  = take_ff;
      issue_in = issue_ff;
      cap_in   = cap_ff;
      pend_in  = 1'b0;
      build_in = build_ff;
      st_we    = 1'b0;
      st_waddr = STACK_AW'(len_ff);
      st_wdata = '0;
      st_raddr = STACK_AW'(pos_ff - LEN_W'(1));
      tb_we    = 1'b0;
      tb_wdata = {prev_ff, cur_ff[7:0]};
      tb_raddr = TBL_AW'(cur_ff);
      chunk    = '0;
      pos_t    = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.valid) begin
               prev_in  = cmd.prev;
               wen_in   = cmd.wr_en;
               waddr_in = cmd.wr_addr;
               st_we    = 1'b1;
               st_waddr = '0;
               if (cmd.first) begin
                  st_wdata = cmd.code[7:0];
                  sym_in   = cmd.code[7:0];
                  pos_t    = LEN_W'(1);
                  state_in = S_EMIT;
               end else if (cmd.kwkwk) begin
                  st_wdata = sym_ff;
                  len_in   = LEN_W'(1);
                  cur_in   = cmd.prev;
                  state_in = S_WALK;
               end else begin
                  st_we    = 1'b0;
                  len_in   = '0;
                  cur_in   = cmd.code;
                  state_in = S_WALK;
               end
            end
         end
         // chain walk: read entry, then push its byte next cycle
         S_WALK: begin
            if (cur_ff >= MAX_CODE_BITS'(256) && len_ff < LEN_W'(STACK_DEPTH - 1)) begin
               state_in = S_WAIT;
            end else begin
               st_we    = 1'b1;
               st_wdata = cur_ff[7:0];
               sym_in   = cur_ff[7:0];
               tb_we    = wen_ff;
               pos_t    = len_ff + LEN_W'(1);
               state_in = S_EMIT;
            end
         end
         S_WAIT: begin
            st_we    = 1'b1;
            st_wdata = tb_rdata[7:0];
            len_in   = len_ff + LEN_W'(1);
            cur_in   = tb_rdata[TW-1:8];
            state_in = S_WALK;
         end
         // gather one chunk, newest stack byte first
         S_EMIT: begin
            if (issue_ff < take_ff) begin
               pos_in   = pos_ff - LEN_W'(1);
               issue_in = issue_ff + CNT_W'(1);
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               build_in[cap_ff[5:0]*8 +: 8] = st_rdata;
               cap_in = cap_ff + CNT_W'(1);
               if (cap_in == take_ff) state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (out_free) begin
               chunk.valid = 1'b1;
               chunk.bytes = build_ff;
               chunk.count = take_ff;
               chunk.last  = (pos_ff == '0);
               if (pos_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  pos_t    = pos_ff;
                  state_in = S_EMIT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // chunk setup whenever a new chunk begins
      if (pos_t != '0) begin
         pos_in   = pos_t;
         take_in  = (pos_t > LEN_W'(CHUNK_BYTES)) ? CNT_W'(CHUNK_BYTES) : CNT_W'(pos_t);
         issue_in = '0;
         cap_in   = '0;
         build_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         sym_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         sym_ff   <= sym_in;
      end
      cur_ff   <= cur_in;
      len_ff   <= len_in;
      pos_ff   <= pos_in;
      prev_ff  <= prev_in;
      wen_ff   <= wen_in;
      waddr_ff <= waddr_in;
      take_ff  <= take_in;
      issue_ff <= issue_in;
      cap_ff   <= cap_in;
      build_ff <= build_in;
   end
endmodule
`default_nettype wire

[rtl/lzw_stream_decoder.sv]
`default_nettype none
// Variable-width LZW decoder, 9 to 12 bit codes, LSB first, one compressed byte
// per req word (tuser = start of stream). Each code's string comes out as up to
// 61 rsp words of 64 bytes, first byte in the low bits, tlast on the last chunk of
// the string. A byte that completes no code does not block req; a byte that
// completes a code blocks req until its string is out: the prefix-table walk
// reads the table RAM once per entry and pushes each byte on the string stack
// RAM, then each chunk is gathered from the stack RAM and handed to the output
// register. A result word waiting in the output register does not hold off the
// next chunk's gathering.
module lzw_stream_decoder (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // in_byte
   input  wire          req_tuser,   // start_of_stream
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [519:0] rsp_tdata,   // lane_0..lane_63, byte_count, zero pad
   output logic         rsp_tlast    // last_of_run
);
   import lzwsd_pkg::*;

   cmd_type    cmd;
   chunk_type  chunk;
   logic       busy, accept, out_free;
   logic       rsp_valid_ff;
   logic [CHUNK_BYTES*8-1:0] rsp_bytes_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic                     rsp_last_ff;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   lzwsd_unpack u_unpack (
      .clock(clock), .reset(reset), .accept(accept), .in_byte(req_tdata),
      .restart(req_tuser), .cmd(cmd)
   );

   lzwsd_expand u_expand (
      .clock(clock), .reset(reset), .cmd(cmd), .out_free(out_free),
      .busy(busy), .chunk(chunk)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chunk.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (chunk.valid) begin
         rsp_bytes_ff <= chunk.bytes;
         rsp_count_ff <= chunk.count;
         rsp_last_ff  <= chunk.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_bytes_ff};
   assign rsp_tlast  = rsp_last_ff;
endmodule
`default_nettype wire
